// File: rtl/tsrl_pkg.sv
// ----------------------------------------------------------------------------
// tsrl_pkg
// Shared constants and codes for the timestamp ring nearest-slot lookup.
// ----------------------------------------------------------------------------
package tsrl_pkg;

    localparam int TSRL_DEPTH        = 1024;  // default number of ring entries
    localparam int SLOT_COUNT_W      = 11;
    localparam int WINDOW_W          = 16;
    localparam int STAMP_W           = 32;
    localparam int SLOT_ID_W         = 11;
    localparam int CFG_DATA_W        = 16;
    localparam int CFG_ADDR_W        = 1;

    localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RESET = 11'd1024;
    localparam logic [WINDOW_W-1:0]     WINDOW_RESET     = 16'd15;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOT_COUNT   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MATCH_WINDOW = 1'b1;

    typedef enum logic [1:0] {
        REQ_RECORD = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_UNUSED = 2'd3
    } req_t;

endpackage

// File: rtl/timestamp_ring_nearest_lookup.sv
// ----------------------------------------------------------------------------
// timestamp_ring_nearest_lookup
// Ring of record timestamps with a nearest-match binary search in age order.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  s_        in         s_tvalid/s_tready  tdata: timestamp; tuser: req_type
//  m_        out        m_tvalid/m_tready  tdata: found, slot_id
//  cfg_      in         cfg_we             cfg_addr selects register, cfg_wdata
//
//  Record, clear and unused requests are answered straight from the idle
//  state. A lookup binary-searches the stored entries: each search probe
//  is one synchronous read of the stamp memory followed by a compare.
//  One item is worked on at a time; a new one is taken while the result
//  register is empty or being drained. Reset is synchronous and active low;
//  the stamp memory is not cleared.
//
module timestamp_ring_nearest_lookup
    import tsrl_pkg::*;
#(
    parameter int DEPTH = TSRL_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [31:0] timestamp
    input  logic [1:0]            s_tuser,   // [1:0] req_type

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [0] found, [11:1] slot_id, [15:12] zero

    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = $clog2(DEPTH + 1);
    localparam int SUM_W  = SLOT_W + 1;
    localparam int CMP_W  = (SLOT_W > SLOT_COUNT_W) ? SLOT_W : SLOT_COUNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_PROBE,
        ST_PREV,
        ST_CHECK,
        ST_FINISH
    } state_t;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t                    state_reg, state_next;
    logic [SLOT_COUNT_W-1:0]   slot_count_reg, slot_count_next;
    logic [WINDOW_W-1:0]       window_reg, window_next;
    logic [SLOT_W-1:0]         write_slot_reg, write_slot_next;
    logic                      wrapped_reg, wrapped_next;
    logic [ADDR_W-1:0]         lo_reg, lo_next;
    logic [ADDR_W-1:0]         hi_reg, hi_next;
    logic [ADDR_W-1:0]         mid_reg, mid_next;
    logic [ADDR_W-1:0]         start0_reg, start0_next;
    logic [SLOT_W-1:0]         n_reg, n_next;
    logic [STAMP_W-1:0]        target_reg, target_next;
    logic [ADDR_W-1:0]         addr_reg, addr_next;
    logic [SLOT_W-1:0]         res_slot_reg, res_slot_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic                      m_found_reg, m_found_next;
    logic [SLOT_ID_W-1:0]      m_slot_reg, m_slot_next;

    // memory
    logic [STAMP_W-1:0]        stamp_mem [DEPTH];
    logic [STAMP_W-1:0]        rdata_reg;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;

    // ------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------
    logic                      out_free;
    logic                      s_accept;
    req_t                      req;
    logic [SLOT_W-1:0]         ring_n;
    logic                      ws_bad;
    logic [SLOT_W-1:0]         rec_slot;
    logic [SUM_W-1:0]          rec_inc;
    logic [SLOT_W-1:0]         lk_w;
    logic                      lk_wrap;
    logic                      lk_empty;
    logic [ADDR_W-1:0]         pos_sel;
    logic [SUM_W-1:0]          pos_sum;
    logic [ADDR_W-1:0]         mid_calc;
    logic [STAMP_W-1:0]        win_ext;
    logic [STAMP_W-1:0]        abs_dist;
    logic [SLOT_W-1:0]         addr_slot;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;
    assign req      = req_t'(s_tuser);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_slot_reg, m_found_reg};

    // ring size clamped to 1..DEPTH
    always_comb begin
        if (slot_count_reg == '0) begin
            ring_n = SLOT_W'(1);
        end else if (CMP_W'(slot_count_reg) > CMP_W'(DEPTH)) begin
            ring_n = SLOT_W'(DEPTH);
        end else begin
            ring_n = SLOT_W'(slot_count_reg);
        end
    end

    assign ws_bad   = (write_slot_reg == '0) || (write_slot_reg > ring_n);
    assign rec_slot = ws_bad ? SLOT_W'(1) : write_slot_reg;
    assign rec_inc  = SUM_W'(rec_slot) + SUM_W'(1);
    assign lk_w     = ws_bad ? SLOT_W'(1) : write_slot_reg;
    assign lk_wrap  = ws_bad || wrapped_reg;
    assign lk_empty = !lk_wrap && (lk_w == SLOT_W'(1));

    assign mid_calc  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign win_ext   = STAMP_W'(window_reg);
    assign abs_dist  = (rdata_reg >= target_reg) ? (rdata_reg - target_reg)
                                                 : (target_reg - rdata_reg);
    assign addr_slot = SLOT_W'(addr_reg) + SLOT_W'(1);

    // age position to memory address, wrapping modulo the ring size
    assign pos_sum = SUM_W'(start0_reg) + SUM_W'(pos_sel);
    assign rd_addr = (pos_sum >= SUM_W'(n_reg)) ? ADDR_W'(pos_sum - SUM_W'(n_reg))
                                                : ADDR_W'(pos_sum);

    assign mem_we    = s_accept && (req == REQ_RECORD);
    assign mem_waddr = ADDR_W'(rec_slot - SLOT_W'(1));

    always_comb begin
        state_next      = state_reg;
        slot_count_next = slot_count_reg;
        window_next     = window_reg;
        write_slot_next = write_slot_reg;
        wrapped_next    = wrapped_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        start0_next     = start0_reg;
        n_next          = n_reg;
        target_next     = target_reg;
        addr_next       = addr_reg;
        res_slot_next   = res_slot_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_found_next    = m_found_reg;
        m_slot_next     = m_slot_reg;
        rd_en           = 1'b0;
        pos_sel         = lo_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_SLOT_COUNT:   slot_count_next = cfg_wdata[SLOT_COUNT_W-1:0];
                CFG_MATCH_WINDOW: window_next     = cfg_wdata[WINDOW_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    target_next = s_tdata;
                    unique case (req)
                        REQ_RECORD: begin
                            m_tvalid_next = 1'b1;
                            m_found_next  = 1'b1;
                            m_slot_next   = SLOT_ID_W'(rec_slot);
                            if (ws_bad) begin
                                wrapped_next = 1'b1;
                            end
                            if (rec_inc > SUM_W'(ring_n)) begin
                                write_slot_next = SLOT_W'(1);
                                wrapped_next    = 1'b1;
                            end else begin
                                write_slot_next = SLOT_W'(rec_inc);
                            end
                        end
                        REQ_LOOKUP: begin
                            if (lk_empty) begin
                                m_tvalid_next = 1'b1;
                                m_found_next  = 1'b0;
                                m_slot_next   = '0;
                            end else begin
                                n_next      = ring_n;
                                lo_next     = '0;
                                start0_next = lk_wrap ? ADDR_W'(lk_w - SLOT_W'(1)) : '0;
                                hi_next     = lk_wrap ? ADDR_W'(ring_n - SLOT_W'(1))
                                                      : ADDR_W'(lk_w - SLOT_W'(2));
                                state_next  = ST_SEARCH;
                            end
                        end
                        REQ_CLEAR: begin
                            write_slot_next = SLOT_W'(1);
                            wrapped_next    = 1'b0;
                            m_tvalid_next   = 1'b1;
                            m_found_next    = 1'b0;
                            m_slot_next     = '0;
                        end
                        default: begin
                            m_tvalid_next = 1'b1;
                            m_found_next  = 1'b0;
                            m_slot_next   = '0;
                        end
                    endcase
                end
            end

            ST_SEARCH: begin
                rd_en = 1'b1;
                if (lo_reg < hi_reg) begin
                    pos_sel    = mid_calc;
                    mid_next   = mid_calc;
                    state_next = ST_PROBE;
                end else if (lo_reg != '0) begin
                    pos_sel    = lo_reg - ADDR_W'(1);
                    state_next = ST_PREV;
                end else begin
                    pos_sel    = lo_reg;
                    state_next = ST_CHECK;
                end
                addr_next = rd_addr;
            end

            ST_PROBE: begin
                if (rdata_reg < target_reg) begin
                    lo_next = mid_reg + ADDR_W'(1);
                end else begin
                    hi_next = mid_reg;
                end
                state_next = ST_SEARCH;
            end

            ST_PREV: begin
                if ((rdata_reg <= target_reg) && ((target_reg - rdata_reg) <= win_ext)) begin
                    res_slot_next = addr_slot;
                    state_next    = ST_FINISH;
                end else begin
                    // fall back to the entry at the search position
                    rd_en      = 1'b1;
                    pos_sel    = lo_reg;
                    addr_next  = rd_addr;
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK: begin
                res_slot_next = (abs_dist <= win_ext) ? addr_slot : '0;
                state_next    = ST_FINISH;
            end

            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_found_next  = (res_slot_reg != '0);
                    m_slot_next   = SLOT_ID_W'(res_slot_reg);
                    state_next    = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            slot_count_reg <= SLOT_COUNT_RESET;
            window_reg     <= WINDOW_RESET;
            write_slot_reg <= SLOT_W'(1);
            wrapped_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            slot_count_reg <= slot_count_next;
            window_reg     <= window_next;
            write_slot_reg <= write_slot_next;
            wrapped_reg    <= wrapped_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        start0_reg   <= start0_next;
        n_reg        <= n_next;
        target_reg   <= target_next;
        addr_reg     <= addr_next;
        res_slot_reg <= res_slot_next;
        m_found_reg  <= m_found_next;
        m_slot_reg   <= m_slot_next;
    end

    // stamp memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stamp_mem[mem_waddr] <= s_tdata;
        end
        if (rd_en) begin
            rdata_reg <= stamp_mem[rd_addr];
        end
    end

endmodule
